>>> rtl/core/rqi_pkg.sv
package rqi_pkg;

    // fixed field widths
    localparam int COORD_W   = 32;
    localparam int REF_W     = 10;
    localparam int REFD_W    = 11;
    localparam int QC_W      = 9;
    localparam int T_W       = 17;
    localparam int IDX_OUT_W = 8;

    // datapath widths: difference terms of the crossing test need 35 bits
    localparam int MUL_W  = 35;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 56;
    localparam int PT_W   = 34;

    localparam logic [1:0] KIND_VERT  = 2'd0;
    localparam logic [1:0] KIND_QUAD  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vert;

    typedef struct packed {
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nz;
        logic [REF_W-1:0]          ref_a;
        logic [REF_W-1:0]          ref_b;
        logic [REF_W-1:0]          ref_c;
        logic [REFD_W-1:0]         ref_d;
    } t_quad;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
    } t_query;

    typedef struct packed {
        logic                      hit;
        logic [T_W-1:0]            t_hit;
        logic [IDX_OUT_W-1:0]      hit_index;
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nz;
    } t_result;

endpackage

>>> rtl/core/ray_quad_intersection_top.sv
// Ray against quad mesh intersection, Q16.16 fixed point.
// Input channel (i_in_valid / o_in_stall): one transaction per item. kind 0
// writes a vertex, kind 1 writes a quad (normal plus vertex refs, ref_d of
// 1024 or more makes a triangle), kind 2 runs a ray query, kind 3 is dropped.
// Writes produce nothing. A query produces exactly one
// transaction on the output channel (o_out_valid / i_out_stall).
// Config channel (i_cfg_valid / o_cfg_ready, always ready) sets quad_count;
// write it only while the block is idle.
// A query checks each quad in use in turn: it stops early for a back-facing
// quad, for one behind the origin or too far, or for one beyond the best t,
// and else runs the full inside test (triangle or quad). The next item can
// be taken as soon as the result appears. A restoring divider and the single
// shared 35x35 multiplier do the arithmetic. o_in_stall stays high for the
// whole query.
// Results sit in an output register; a stalled result holds there and the
// engine waits only if a second result is ready before the first is taken.
// Reset (synchronous, active low) clears quad_count and the control state.
// Vertex and quad stores are not cleared: write every entry a query uses.
module ray_quad_intersection_top #(
    parameter int MAX_QUADS = 256,
    parameter int MAX_VERTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [9:0]         i_slot,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_bz,
    input  logic [9:0]         i_ref_a,
    input  logic [9:0]         i_ref_b,
    input  logic [9:0]         i_ref_c,
    input  logic [10:0]        i_ref_d,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_hit,
    output logic [16:0]        o_t_hit,
    output logic [7:0]         o_hit_index,
    output logic signed [31:0] o_normal_x,
    output logic signed [31:0] o_normal_y,
    output logic signed [31:0] o_normal_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [8:0]         i_cfg_quad_count
);
    import rqi_pkg::*;

    localparam int QAW = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1;
    localparam int VAW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;

    logic [QC_W-1:0]  r_quad_count;
    logic             r_out_valid;
    t_result          r_out;

    logic             accept;
    logic             vert_we, quad_we, start;
    logic             eng_ready, res_valid, res_ready;
    t_result          res;
    t_query           query;
    t_vert            vert_wdata, vert_q;
    t_quad            quad_wdata, quad_q;
    logic [QAW-1:0]   quad_raddr;
    logic [VAW-1:0]   vert_raddr;

    // an item is taken only while the engine is idle
    assign o_in_stall = !eng_ready;
    assign accept     = i_in_valid && !o_in_stall;

    // out-of-range slots are silently dropped
    assign vert_we = accept && (i_kind == KIND_VERT) && (32'(i_slot) < 32'(MAX_VERTS));
    assign quad_we = accept && (i_kind == KIND_QUAD) && (32'(i_slot) < 32'(MAX_QUADS));
    assign start   = accept && (i_kind == KIND_QUERY);

    always_comb begin
        vert_wdata.x     = i_ax;
        vert_wdata.y     = i_ay;
        vert_wdata.z     = i_az;
        quad_wdata.nx    = i_ax;
        quad_wdata.ny    = i_ay;
        quad_wdata.nz    = i_az;
        quad_wdata.ref_a = i_ref_a;
        quad_wdata.ref_b = i_ref_b;
        quad_wdata.ref_c = i_ref_c;
        quad_wdata.ref_d = i_ref_d;
        query.ax         = i_ax;
        query.ay         = i_ay;
        query.az         = i_az;
        query.bx         = i_bx;
        query.by         = i_by;
        query.bz         = i_bz;
    end

    rqi_ram #(
        .WIDTH ($bits(t_vert)),
        .DEPTH (MAX_VERTS)
    ) u_vert_ram (
        .i_clk   (i_clk),
        .i_we    (vert_we),
        .i_waddr (VAW'(i_slot)),
        .i_wdata (vert_wdata),
        .i_raddr (vert_raddr),
        .o_rdata (vert_q)
    );

    rqi_ram #(
        .WIDTH ($bits(t_quad)),
        .DEPTH (MAX_QUADS)
    ) u_quad_ram (
        .i_clk   (i_clk),
        .i_we    (quad_we),
        .i_waddr (QAW'(i_slot)),
        .i_wdata (quad_wdata),
        .i_raddr (quad_raddr),
        .o_rdata (quad_q)
    );

    rqi_engine #(
        .MAX_QUADS (MAX_QUADS),
        .MAX_VERTS (MAX_VERTS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_query      (query),
        .i_quad_count (r_quad_count),
        .o_ready      (eng_ready),
        .o_quad_raddr (quad_raddr),
        .i_quad_q     (quad_q),
        .o_vert_raddr (vert_raddr),
        .i_vert_q     (vert_q),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // config register, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad_count <= '0;
        end else if (i_cfg_valid) begin
            r_quad_count <= i_cfg_quad_count;
        end
    end

    // output register: loads when empty or when its transaction completes
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out.hit;
    assign o_t_hit     = r_out.t_hit;
    assign o_hit_index = r_out.hit_index;
    assign o_normal_x  = r_out.nx;
    assign o_normal_y  = r_out.ny;
    assign o_normal_z  = r_out.nz;

endmodule

>>> rtl/core/rqi_ram.sv
module rqi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/rqi_mul.sv
module rqi_mul (
    input  logic                               i_clk,
    input  logic signed [rqi_pkg::MUL_W-1:0]   i_op_a,
    input  logic signed [rqi_pkg::MUL_W-1:0]   i_op_b,
    output logic signed [rqi_pkg::PROD_W-1:0]  o_prod
);
    import rqi_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // product registered, used in the following cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/core/rqi_engine.sv
module rqi_engine #(
    parameter int MAX_QUADS = 256,
    parameter int MAX_VERTS = 1024,
    localparam int QAW = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1,
    localparam int QCW = $clog2(MAX_QUADS + 1),
    localparam int VAW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  rqi_pkg::t_query               i_query,
    input  logic [rqi_pkg::QC_W-1:0]      i_quad_count,
    output logic                          o_ready,
    output logic [QAW-1:0]                o_quad_raddr,
    input  rqi_pkg::t_quad                i_quad_q,
    output logic [VAW-1:0]                o_vert_raddr,
    input  rqi_pkg::t_vert                i_vert_q,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output rqi_pkg::t_result              o_res
);
    import rqi_pkg::*;

    localparam int RECIP_SH = 22;
    localparam int RECIP    = ((1 << RECIP_SH) + MAX_VERTS - 1) / MAX_VERTS;

    typedef enum logic [24:0] {
        S_IDLE  = 25'h0000001,
        S_QRD   = 25'h0000002,
        S_QLAT  = 25'h0000004,
        S_D1    = 25'h0000008,
        S_D2    = 25'h0000010,
        S_D3    = 25'h0000020,
        S_N1    = 25'h0000040,
        S_N2    = 25'h0000080,
        S_N3    = 25'h0000100,
        S_N4    = 25'h0000200,
        S_N5    = 25'h0000400,
        S_N6    = 25'h0000800,
        S_NCHK  = 25'h0001000,
        S_DIV   = 25'h0002000,
        S_TCHK  = 25'h0004000,
        S_P1    = 25'h0008000,
        S_P2    = 25'h0010000,
        S_P3    = 25'h0020000,
        S_XINIT = 25'h0040000,
        S_XLAT  = 25'h0080000,
        S_XM1   = 25'h0100000,
        S_XM2   = 25'h0200000,
        S_XCMP  = 25'h0400000,
        S_NEXT  = 25'h0800000,
        S_OUT   = 25'h1000000
    } t_state;

    // reference modulo vertex count by reciprocal; exact for 11-bit refs
    function automatic logic [VAW-1:0] vmod(input logic [REFD_W-1:0] ref_in);
        logic [39:0] prod;
        logic [39:0] quo;
        logic [39:0] rem;
        prod = 40'(ref_in) * 40'(RECIP);
        quo  = prod >> RECIP_SH;
        rem  = 40'(ref_in) - quo * 40'(MAX_VERTS);
        return VAW'(rem);
    endfunction

    function automatic logic [REFD_W-1:0] ref_of(input t_quad q, input logic [1:0] j);
        case (j)
            2'd0:    return {1'b0, q.ref_a};
            2'd1:    return {1'b0, q.ref_b};
            2'd2:    return {1'b0, q.ref_c};
            default: return q.ref_d;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] vsel(input t_vert v, input logic [1:0] c);
        case (c)
            COMP_X:  return v.x;
            COMP_Y:  return v.y;
            default: return v.z;
        endcase
    endfunction

    function automatic logic signed [PT_W-1:0] psel(
        input logic signed [PT_W-1:0] px,
        input logic signed [PT_W-1:0] py,
        input logic signed [PT_W-1:0] pz,
        input logic [1:0]             c
    );
        case (c)
            COMP_X:  return px;
            COMP_Y:  return py;
            default: return pz;
        endcase
    endfunction

    function automatic logic [COORD_W:0] mag(input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W:0] e;
        e = (COORD_W+1)'(v);
        return v[COORD_W-1] ? -e : e;
    endfunction

    t_state                     r_state, n_state;
    t_query                     r_q;
    t_quad                      r_quad;
    t_vert                      r_v0;
    logic [QCW-1:0]             r_nq, r_i;
    logic signed [ACC_W-1:0]    r_acc, r_den;
    logic [ACC_W-1:0]           r_rem, r_ad;
    logic [3:0]                 r_cnt;
    logic [15:0]                r_t;
    logic signed [PT_W-1:0]     r_pt_x, r_pt_y, r_pt_z;
    logic [1:0]                 r_u, r_w, r_j;
    logic signed [MUL_W-1:0]    r_dx2, r_dy2, r_dx1, r_dy1;
    logic                       r_xs2, r_ys2, r_inside;
    logic signed [PROD_W-1:0]   r_p1;
    logic [T_W-1:0]             r_best_t;
    logic                       r_hit;
    logic [QAW-1:0]             r_best_i;
    logic signed [COORD_W-1:0]  r_best_nx, r_best_ny, r_best_nz;

    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    p16, acc_add, acc_sub;
    logic [ACC_W-1:0]           an, ad, rem2;
    logic                       num_pos, ge;
    logic [QCW-1:0]             nq_in, i_inc;
    logic signed [MUL_W-1:0]    tz;
    logic [1:0]                 j_init, dom_u, dom_w;
    logic [COORD_W:0]           ex, ey, ez;
    logic signed [MUL_W-1:0]    d0u, d0w, d1u, d1w;
    logic                       xs1, ys1, gt, dyg, inside_n;

    rqi_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (mul_a),
        .i_op_b (mul_b),
        .o_prod (prod)
    );

    assign p16     = ACC_W'(prod >>> 16);
    assign acc_add = r_acc + p16;
    assign acc_sub = r_acc - p16;
    assign an      = -r_acc;
    assign ad      = -r_den;
    assign num_pos = !r_acc[ACC_W-1] && (r_acc != '0);
    assign rem2    = {r_rem[ACC_W-2:0], 1'b0};
    assign ge      = rem2 >= r_ad;
    assign tz      = $signed(MUL_W'(r_t));
    assign i_inc   = r_i + QCW'(1);
    assign nq_in   = (32'(i_quad_count) > 32'(MAX_QUADS)) ? QCW'(MAX_QUADS)
                                                          : QCW'(i_quad_count);
    assign j_init  = r_quad.ref_d[REFD_W-1] ? 2'd2 : 2'd3;

    // dominant axis of the normal, ties fall to the xy plane
    assign ex = mag(r_quad.nx);
    assign ey = mag(r_quad.ny);
    assign ez = mag(r_quad.nz);
    always_comb begin
        if (ex > ey && ex > ez) begin
            dom_u = COMP_Y;
            dom_w = COMP_Z;
        end else if (ey > ex && ey > ez) begin
            dom_u = COMP_Z;
            dom_w = COMP_X;
        end else begin
            dom_u = COMP_X;
            dom_w = COMP_Y;
        end
    end

    assign d0u = MUL_W'(vsel(r_v0, r_u)) - MUL_W'(psel(r_pt_x, r_pt_y, r_pt_z, r_u));
    assign d0w = MUL_W'(vsel(r_v0, r_w)) - MUL_W'(psel(r_pt_x, r_pt_y, r_pt_z, r_w));
    assign d1u = MUL_W'(vsel(i_vert_q, r_u)) - MUL_W'(psel(r_pt_x, r_pt_y, r_pt_z, r_u));
    assign d1w = MUL_W'(vsel(i_vert_q, r_w)) - MUL_W'(psel(r_pt_x, r_pt_y, r_pt_z, r_w));

    // crossing-count step for one edge
    assign xs1 = !r_dx1[MUL_W-1] && (r_dx1 != '0);
    assign ys1 = !r_dy1[MUL_W-1] && (r_dy1 != '0);
    assign gt  = r_p1 > prod;
    assign dyg = r_dy2 > r_dy1;
    always_comb begin
        inside_n = r_inside;
        if (ys1 != r_ys2) begin
            if (xs1 != r_xs2) begin
                if (gt != dyg) begin
                    inside_n = !r_inside;
                end
            end else if (xs1) begin
                inside_n = !r_inside;
            end
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_QLAT: begin
                mul_a = MUL_W'(i_quad_q.nx);
                mul_b = MUL_W'(r_q.bx);
            end
            S_D1: begin
                mul_a = MUL_W'(r_quad.ny);
                mul_b = MUL_W'(r_q.by);
            end
            S_D2: begin
                mul_a = MUL_W'(r_quad.nz);
                mul_b = MUL_W'(r_q.bz);
            end
            S_D3: begin
                mul_a = MUL_W'(r_quad.nx);
                mul_b = MUL_W'(r_v0.x);
            end
            S_N1: begin
                mul_a = MUL_W'(r_quad.ny);
                mul_b = MUL_W'(r_v0.y);
            end
            S_N2: begin
                mul_a = MUL_W'(r_quad.nz);
                mul_b = MUL_W'(r_v0.z);
            end
            S_N3: begin
                mul_a = MUL_W'(r_quad.nx);
                mul_b = MUL_W'(r_q.ax);
            end
            S_N4: begin
                mul_a = MUL_W'(r_quad.ny);
                mul_b = MUL_W'(r_q.ay);
            end
            S_N5: begin
                mul_a = MUL_W'(r_quad.nz);
                mul_b = MUL_W'(r_q.az);
            end
            S_TCHK: begin
                mul_a = MUL_W'(r_q.bx);
                mul_b = tz;
            end
            S_P1: begin
                mul_a = MUL_W'(r_q.by);
                mul_b = tz;
            end
            S_P2: begin
                mul_a = MUL_W'(r_q.bz);
                mul_b = tz;
            end
            S_XM1: begin
                mul_a = r_dx2;
                mul_b = r_dy1;
            end
            S_XM2: begin
                mul_a = r_dx1;
                mul_b = r_dy2;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_QLAT:  o_vert_raddr = vmod({1'b0, i_quad_q.ref_a});
            S_XINIT: o_vert_raddr = vmod(ref_of(r_quad, j_init));
            S_XCMP:  o_vert_raddr = vmod(ref_of(r_quad, r_j - 2'd1));
            default: o_vert_raddr = vmod({1'b0, r_quad.ref_a});
        endcase
    end

    assign o_quad_raddr = r_i[QAW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) begin
                n_state = (nq_in == '0) ? S_OUT : S_QRD;
            end
            S_QRD:   n_state = S_QLAT;
            S_QLAT:  n_state = S_D1;
            S_D1:    n_state = S_D2;
            S_D2:    n_state = S_D3;
            S_D3:    n_state = acc_add[ACC_W-1] ? S_N1 : S_NEXT;
            S_N1:    n_state = S_N2;
            S_N2:    n_state = S_N3;
            S_N3:    n_state = S_N4;
            S_N4:    n_state = S_N5;
            S_N5:    n_state = S_N6;
            S_N6:    n_state = S_NCHK;
            S_NCHK:  n_state = (num_pos || an >= ad) ? S_NEXT : S_DIV;
            S_DIV:   if (r_cnt == 4'd15) begin
                n_state = S_TCHK;
            end
            S_TCHK:  n_state = ({1'b0, r_t} >= r_best_t) ? S_NEXT : S_P1;
            S_P1:    n_state = S_P2;
            S_P2:    n_state = S_P3;
            S_P3:    n_state = S_XINIT;
            S_XINIT: n_state = S_XLAT;
            S_XLAT:  n_state = S_XM1;
            S_XM1:   n_state = S_XM2;
            S_XM2:   n_state = S_XCMP;
            S_XCMP:  n_state = (r_j == 2'd0) ? S_NEXT : S_XLAT;
            S_NEXT:  n_state = (i_inc == r_nq) ? S_OUT : S_QRD;
            S_OUT:   if (i_res_ready) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hit    <= 1'b0;
            r_best_t <= ONE_Q16;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_start) begin
                r_hit    <= 1'b0;
                r_best_t <= ONE_Q16;
            end else if (r_state == S_XCMP && r_j == 2'd0 && inside_n) begin
                r_hit    <= 1'b1;
                r_best_t <= {1'b0, r_t};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_start) begin
                r_q       <= i_query;
                r_nq      <= nq_in;
                r_i       <= '0;
                r_best_i  <= '0;
                r_best_nx <= '0;
                r_best_ny <= '0;
                r_best_nz <= '0;
            end
            S_QLAT: r_quad <= i_quad_q;
            S_D1: begin
                r_v0  <= i_vert_q;
                r_acc <= p16;
            end
            S_D2:   r_acc <= acc_add;
            S_D3:   r_den <= acc_add;
            S_N1:   r_acc <= p16;
            S_N2:   r_acc <= acc_add;
            S_N3:   r_acc <= acc_add;
            S_N4:   r_acc <= acc_sub;
            S_N5:   r_acc <= acc_sub;
            S_N6:   r_acc <= acc_sub;
            S_NCHK: begin
                r_rem <= an;
                r_ad  <= ad;
                r_cnt <= '0;
                r_t   <= '0;
            end
            S_DIV: begin
                r_rem <= ge ? rem2 - r_ad : rem2;
                r_t   <= {r_t[14:0], ge};
                r_cnt <= r_cnt + 4'd1;
            end
            S_P1:   r_pt_x <= PT_W'(r_q.ax) + PT_W'(p16);
            S_P2:   r_pt_y <= PT_W'(r_q.ay) + PT_W'(p16);
            S_P3: begin
                r_pt_z <= PT_W'(r_q.az) + PT_W'(p16);
                r_u    <= dom_u;
                r_w    <= dom_w;
            end
            S_XINIT: begin
                r_dx2    <= d0u;
                r_dy2    <= d0w;
                r_xs2    <= !d0u[MUL_W-1] && (d0u != '0);
                r_ys2    <= !d0w[MUL_W-1] && (d0w != '0);
                r_inside <= 1'b0;
                r_j      <= j_init;
            end
            S_XLAT: begin
                r_dx1 <= d1u;
                r_dy1 <= d1w;
            end
            S_XM2:  r_p1 <= prod;
            S_XCMP: begin
                r_inside <= inside_n;
                r_xs2    <= xs1;
                r_ys2    <= ys1;
                r_dx2    <= r_dx1;
                r_dy2    <= r_dy1;
                r_j      <= r_j - 2'd1;
                if (r_j == 2'd0 && inside_n) begin
                    r_best_i  <= r_i[QAW-1:0];
                    r_best_nx <= r_quad.nx;
                    r_best_ny <= r_quad.ny;
                    r_best_nz <= r_quad.nz;
                end
            end
            S_NEXT: r_i <= i_inc;
            default: begin
            end
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);

    always_comb begin
        o_res.hit       = r_hit;
        o_res.t_hit     = r_best_t;
        o_res.hit_index = IDX_OUT_W'(r_best_i);
        o_res.nx        = r_best_nx;
        o_res.ny        = r_best_ny;
        o_res.nz        = r_best_nz;
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("query started while engine busy");

    a_best_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_t <= ONE_Q16)
        else $error("best t above one");

    a_nohit_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hit |-> (r_best_t == ONE_Q16))
        else $error("best t moved without a hit");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_ad))
        else $error("divider remainder out of range");

    a_quad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRD) |-> (r_i < r_nq))
        else $error("quad index beyond count");

endmodule

>>> tb/rqi_checker.sv
`timescale 1ns / 100ps

// Watches the input, config and result channels, predicts each ray result
// and compares it with what the block returns.
module rqi_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [9:0]         i_slot,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_bz,
    input  logic [9:0]         i_ref_a,
    input  logic [9:0]         i_ref_b,
    input  logic [9:0]         i_ref_c,
    input  logic [10:0]        i_ref_d,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic               o_hit,
    input  logic [16:0]        o_t_hit,
    input  logic [7:0]         o_hit_index,
    input  logic signed [31:0] o_normal_x,
    input  logic signed [31:0] o_normal_y,
    input  logic signed [31:0] o_normal_z,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [8:0]         i_cfg_quad_count,
    output int                 o_mismatches,
    output int                 o_pending
);
    import rqi_pkg::*;

    localparam int N_QUADS = 256;
    localparam int N_VERTS = 1024;

    typedef longint t_vec3 [3];

    logic signed [31:0] vert_x [N_VERTS];
    logic signed [31:0] vert_y [N_VERTS];
    logic signed [31:0] vert_z [N_VERTS];
    logic signed [31:0] quad_nx [N_QUADS];
    logic signed [31:0] quad_ny [N_QUADS];
    logic signed [31:0] quad_nz [N_QUADS];
    logic [9:0]         quad_ra [N_QUADS];
    logic [9:0]         quad_rb [N_QUADS];
    logic [9:0]         quad_rc [N_QUADS];
    logic [10:0]        quad_rd [N_QUADS];
    logic [8:0]         quad_count;
    t_result            ray_results_q [$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        quad_count   = '0;
    end

    function automatic longint vert_coord(int idx, int axis);
        if (axis == 0) return vert_x[idx];
        if (axis == 1) return vert_y[idx];
        return vert_z[idx];
    endfunction

    // component products floored to Q16.16, summed exactly
    function automatic longint fix_dot(t_vec3 a, t_vec3 b);
        return ((a[0] * b[0]) >>> 16) + ((a[1] * b[1]) >>> 16) + ((a[2] * b[2]) >>> 16);
    endfunction

    function automatic bit cross_greater(longint a, longint b, longint c, longint d);
        logic signed [127:0] wa, wb, wc, wd;
        wa = a;
        wb = b;
        wc = c;
        wd = d;
        return (wa * wb) > (wc * wd);
    endfunction

    function automatic t_result trace_ray(t_vec3 o, t_vec3 r);
        t_result    res;
        int         nq, nv, u, w;
        int         idx [4];
        logic [63:0] best_t, t, uan, uad;
        t_vec3      n, v0, pt;
        longint     den, num, ex, ey, ez, dx1, dy1, dx2, dy2;
        logic       xs1, ys1, xs2, ys2, in_poly;
        res       = '0;
        res.t_hit = ONE_Q16;
        best_t    = 64'h10000;
        nq        = (int'(quad_count) > N_QUADS) ? N_QUADS : int'(quad_count);
        for (int i = 0; i < nq; i++) begin
            n[0] = quad_nx[i];
            n[1] = quad_ny[i];
            n[2] = quad_nz[i];
            den  = fix_dot(n, r);
            if (den >= 0) continue;
            idx[0] = int'(quad_ra[i]);
            idx[1] = int'(quad_rb[i]);
            idx[2] = int'(quad_rc[i]);
            idx[3] = int'(quad_rd[i][9:0]);
            nv     = quad_rd[i][10] ? 3 : 4;
            for (int k = 0; k < 3; k++) v0[k] = vert_coord(idx[0], k);
            num = fix_dot(n, v0) - fix_dot(n, o);
            if (num > 0) continue;
            uan = -num;
            uad = -den;
            if (uan >= uad) continue;
            t = (uan << 16) / uad;
            if (t >= best_t) continue;
            for (int k = 0; k < 3; k++) pt[k] = o[k] + ((r[k] * longint'(t)) >>> 16);

            // drop the axis of the largest normal component; ties fall to xy
            ex = (n[0] < 0) ? -n[0] : n[0];
            ey = (n[1] < 0) ? -n[1] : n[1];
            ez = (n[2] < 0) ? -n[2] : n[2];
            if (ex > ey && ex > ez) begin
                u = 1; w = 2;
            end else if (ey > ex && ey > ez) begin
                u = 2; w = 0;
            end else begin
                u = 0; w = 1;
            end

            dx2     = vert_coord(idx[0], u) - pt[u];
            dy2     = vert_coord(idx[0], w) - pt[w];
            xs2     = dx2 > 0;
            ys2     = dy2 > 0;
            in_poly = 1'b0;
            for (int j = nv - 1; j >= 0; j--) begin
                dx1 = vert_coord(idx[j], u) - pt[u];
                dy1 = vert_coord(idx[j], w) - pt[w];
                xs1 = dx1 > 0;
                ys1 = dy1 > 0;
                if (ys1 != ys2) begin
                    if (xs1 != xs2) begin
                        if (cross_greater(dx2, dy1, dx1, dy2) != (dy2 > dy1))
                            in_poly = !in_poly;
                    end else if (xs1) begin
                        in_poly = !in_poly;
                    end
                    ys2 = ys1;
                end
                xs2 = xs1;
                dx2 = dx1;
                dy2 = dy1;
            end
            if (in_poly) begin
                best_t        = t;
                res.hit       = 1'b1;
                res.t_hit     = t[16:0];
                res.hit_index = 8'(i);
                res.nx        = n[0][31:0];
                res.ny        = n[1][31:0];
                res.nz        = n[2][31:0];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want, got;
        t_vec3   org, dir;
        if (!i_rst_n) begin
            quad_count = '0;
            ray_results_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) quad_count = i_cfg_quad_count;

            if (o_out_valid && !i_out_stall) begin
                got = {o_hit, o_t_hit, o_hit_index, o_normal_x, o_normal_y, o_normal_z};
                if (ray_results_q.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("%0t: ray result with none outstanding: hit=%0d t=%h", $realtime,
                                 got.hit, got.t_hit);
                end else begin
                    want = ray_results_q.pop_front();
                    if (got.hit !== want.hit || got.t_hit !== want.t_hit ||
                        got.hit_index !== want.hit_index || got.nx !== want.nx ||
                        got.ny !== want.ny || got.nz !== want.nz) begin
                        o_mismatches++;
                        if (o_mismatches <= 10) begin
                            $display("%0t: ray result mismatch", $realtime);
                            $display("  expected hit=%0d t=%h idx=%0d n=(%h,%h,%h)", want.hit,
                                     want.t_hit, want.hit_index, want.nx, want.ny, want.nz);
                            $display("  actual   hit=%0d t=%h idx=%0d n=(%h,%h,%h)", got.hit,
                                     got.t_hit, got.hit_index, got.nx, got.ny, got.nz);
                        end
                    end
                end
            end

            if (i_in_valid && !o_in_stall) begin
                case (i_kind)
                    KIND_VERT: begin
                        vert_x[i_slot] = i_ax;
                        vert_y[i_slot] = i_ay;
                        vert_z[i_slot] = i_az;
                    end
                    KIND_QUAD: begin
                        if (i_slot < N_QUADS) begin
                            quad_nx[i_slot] = i_ax;
                            quad_ny[i_slot] = i_ay;
                            quad_nz[i_slot] = i_az;
                            quad_ra[i_slot] = i_ref_a;
                            quad_rb[i_slot] = i_ref_b;
                            quad_rc[i_slot] = i_ref_c;
                            quad_rd[i_slot] = i_ref_d;
                        end
                    end
                    KIND_QUERY: begin
                        org[0] = i_ax; org[1] = i_ay; org[2] = i_az;
                        dir[0] = i_bx; dir[1] = i_by; dir[2] = i_bz;
                        ray_results_q.push_back(trace_ray(org, dir));
                    end
                    default: ;
                endcase
            end
        end
        o_pending = ray_results_q.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the ray/quad intersection block. Prediction and
// comparison live in rqi_checker; this module only drives transactions.
module tb;
    import rqi_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;  // undefined kind, dropped by the block
    localparam int U = 65536;                 // 1.0 in Q16.16

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_kind;
    logic [9:0]         i_slot;
    logic signed [31:0] i_ax, i_ay, i_az, i_bx, i_by, i_bz;
    logic [9:0]         i_ref_a, i_ref_b, i_ref_c;
    logic [10:0]        i_ref_d;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_hit;
    logic [16:0]        o_t_hit;
    logic [7:0]         o_hit_index;
    logic signed [31:0] o_normal_x, o_normal_y, o_normal_z;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [8:0]         i_cfg_quad_count;

    int mismatches;
    int pending;

    // stimulus knobs
    bit quiet;          // no idling on either side
    bit hold_go;        // request for the long receiver hold-off
    bit hold_on;
    int out_gap;
    bit random_phase;
    int random_items;

    // scene bookkeeping for aimed rays
    int pool_base;
    int sq_axis [4];
    int sq_c    [4][3];
    int sq_h    [4];
    int quad_sq [256];
    int quad_sg [256];
    int scene_quads;

    ray_quad_intersection_top u_dut (.*);

    rqi_checker u_checker (
        .*,
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #30_000_000;
        $display("** ray_quad_intersection_top: FAILED **");
        $finish;
    end

    // long hold-off on the result side so the engine backs up onto the input
    initial begin
        hold_on = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        hold_on = 1'b1;
        repeat (2500) @(posedge i_clk);
        hold_on = 1'b0;
    end

    // result side: a random stall after every transaction taken
    initial begin
        out_gap     = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) out_gap = quiet ? 0 : $urandom_range(0, 11);
            @(negedge i_clk);
            i_out_stall <= hold_on || (out_gap > 0);
            if (out_gap > 0) out_gap--;
        end
    end

    task automatic send(input logic [1:0] kind, input logic [9:0] slot,
                        input int ax, input int ay, input int az,
                        input int bx, input int by, input int bz,
                        input logic [9:0] ra, input logic [9:0] rb, input logic [9:0] rc,
                        input logic [10:0] rd);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_slot     <= slot;
        i_ax       <= ax;
        i_ay       <= ay;
        i_az       <= az;
        i_bx       <= bx;
        i_by       <= by;
        i_bz       <= bz;
        i_ref_a    <= ra;
        i_ref_b    <= rb;
        i_ref_c    <= rc;
        i_ref_d    <= rd;
        do @(posedge i_clk); while (o_in_stall);
        if (random_phase) random_items++;
    endtask

    task automatic put_vertex(input int slot, input int x, input int y, input int z);
        send(KIND_VERT, 10'(slot), x, y, z, $urandom, $urandom, $urandom,
             10'($urandom), 10'($urandom), 10'($urandom), 11'($urandom));
    endtask

    task automatic cast_ray(input int ox, input int oy, input int oz,
                            input int dx, input int dy, input int dz);
        send(KIND_QUERY, 10'($urandom), ox, oy, oz, dx, dy, dz,
             10'($urandom), 10'($urandom), 10'($urandom), 11'($urandom));
    endtask

    // drop valid, let every outstanding result drain, then a short settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_quad_count(input int count);
        wait_idle();
        i_cfg_valid      <= 1'b1;
        i_cfg_quad_count <= 9'(count);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int rand_span(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // four axis-aligned squares in a 16-vertex pool, then nq quads on them
    task automatic build_scene(input int nq);
        int s, m, ax, u, w, sg, rot, p [3], n [3];
        logic [9:0]  r [4];
        logic [9:0]  swap;
        logic [10:0] rd;
        pool_base = $urandom_range(0, 1008);
        for (s = 0; s < 4; s++) begin
            ax = $urandom_range(0, 2);
            u  = (ax + 1) % 3;
            w  = (ax + 2) % 3;
            sq_axis[s] = ax;
            sq_h[s]    = rand_span(U / 2, 20 * U);
            for (int k = 0; k < 3; k++) sq_c[s][k] = rand_span(-50 * U, 50 * U);
            for (m = 0; m < 4; m++) begin
                p[ax] = sq_c[s][ax];
                p[u]  = sq_c[s][u] + ((m == 1 || m == 2) ? sq_h[s] : -sq_h[s]);
                p[w]  = sq_c[s][w] + ((m >= 2) ? sq_h[s] : -sq_h[s]);
                put_vertex(pool_base + 4 * s + m, p[0], p[1], p[2]);
            end
        end
        // noise: dropped kind, quad write past the store, stray vertex
        send(KIND_NONE, 10'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, 10'($urandom), 10'($urandom), 10'($urandom), 11'($urandom));
        send(KIND_QUAD, 10'($urandom_range(256, 1023)), $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, 10'($urandom), 10'($urandom), 10'($urandom),
             11'($urandom));
        put_vertex($urandom_range(0, 1023), $urandom, $urandom, $urandom);
        for (int q = 0; q < nq; q++) begin
            s  = $urandom_range(0, 3);
            ax = sq_axis[s];
            u  = (ax + 1) % 3;
            w  = (ax + 2) % 3;
            sg = $urandom_range(0, 1) ? 1 : -1;
            n[ax] = sg * rand_span(U / 2, 2 * U);
            n[u]  = rand_span(-U / 4, U / 4);
            n[w]  = rand_span(-U / 4, U / 4);
            if ($urandom_range(0, 7) == 0) n[u] = $urandom_range(0, 1) ? n[ax] : -n[ax];
            rot = $urandom_range(0, 3);
            for (int j = 0; j < 4; j++) r[j] = 10'(pool_base + 4 * s + ((j + rot) % 4));
            if ($urandom_range(0, 5) == 0) begin
                swap = r[1];
                r[1] = r[2];
                r[2] = swap;
            end
            rd = ($urandom_range(0, 3) == 0) ? 11'(1024 + $urandom_range(0, 1023)) : 11'(r[3]);
            quad_sq[q] = s;
            quad_sg[q] = sg;
            send(KIND_QUAD, 10'(q), n[0], n[1], n[2], $urandom, $urandom, $urandom,
                 r[0], r[1], r[2], rd);
        end
        scene_quads = nq;
    endtask

    // mostly rays aimed at a chosen quad; some reversed, short or pure noise
    task automatic aimed_query();
        int q, s, ax, u, w, sg, d, len, h, mode, o [3], dir [3];
        mode = $urandom_range(0, 9);
        if (mode == 9) begin
            cast_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            q  = $urandom_range(0, (scene_quads > 256 ? 256 : scene_quads) - 1);
            s  = quad_sq[q];
            ax = sq_axis[s];
            u  = (ax + 1) % 3;
            w  = (ax + 2) % 3;
            sg = quad_sg[q];
            h  = sq_h[s];
            d  = rand_span(U / 4, 30 * U);
            len = (mode == 8) ? rand_span(d / 4, d) : d + rand_span(d / 8, 2 * d);
            o[ax]   = sq_c[s][ax] + sg * d;
            o[u]    = sq_c[s][u] + rand_span(-(h + h / 4), h + h / 4);
            o[w]    = sq_c[s][w] + rand_span(-(h + h / 4), h + h / 4);
            dir[ax] = (mode == 7) ? sg * len : -sg * len;
            dir[u]  = rand_span(-h / 4, h / 4);
            dir[w]  = rand_span(-h / 4, h / 4);
            cast_ray(o[0], o[1], o[2], dir[0], dir[1], dir[2]);
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_kind           = KIND_VERT;
        i_slot           = '0;
        {i_ax, i_ay, i_az, i_bx, i_by, i_bz} = '0;
        {i_ref_a, i_ref_b, i_ref_c, i_ref_d} = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_quad_count = '0;
        quiet            = 1'b0;
        hold_go          = 1'b0;
        random_phase     = 1'b0;
        random_items     = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, a square from -1 to 1 in z=0, every skip path
        set_quad_count(0);
        put_vertex(0, 32'sh7fffffff, 32'sh80000000, 0);
        put_vertex(1023, 32'sh80000000, 32'sh7fffffff, -1);
        put_vertex(4, -U, -U, 0);
        put_vertex(5, U, -U, 0);
        put_vertex(6, U, U, 0);
        put_vertex(7, -U, U, 0);
        send(KIND_QUAD, 0, 0, 0, U, 0, 0, 0, 4, 5, 6, 7);
        send(KIND_QUAD, 1, 0, 0, 2 * U, 0, 0, 0, 4, 5, 6, 11'd2047);  // triangle
        send(KIND_QUAD, 2, 0, 0, -U, 0, 0, 0, 4, 5, 6, 7);            // faces up the ray
        send(KIND_QUAD, 3, U, -U, U, 0, 0, 0, 4, 5, 6, 7);            // all-axis tie
        send(KIND_QUAD, 255, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 0,
             0, 1023, 4, 11'd1024);
        send(KIND_QUAD, 1023, U, U, U, -1, -1, -1, 10'h3ff, 10'h3ff, 10'h3ff, 11'h7ff);
        send(KIND_NONE, 1023, -1, -1, -1, -1, -1, -1, 10'h3ff, 10'h3ff, 10'h3ff, 11'h7ff);
        cast_ray(U / 4, U / 4, U, 0, 0, -2 * U);                       // no quads in use
        set_quad_count(4);
        cast_ray(U / 4, U / 4, U, 0, 0, -2 * U);                       // plain hit, t = 0.5
        cast_ray(-U / 2, U / 2, U, 0, 0, -4 * U);                      // triangle corner miss
        cast_ray(0, 0, -U, 0, 0, -U);                                  // behind the origin
        cast_ray(0, 0, U, 0, 0, 2 * U);                                // facing away
        cast_ray(0, 0, U, U, 0, 0);                                    // parallel
        cast_ray(0, 0, U, 0, 0, -U / 2);                               // too far
        cast_ray(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        cast_ray(3 * U, 0, U, 0, 0, -2 * U);                           // outside laterally

        // random scenes; every fourth runs with no idling, one meets the long hold-off
        random_phase = 1'b1;
        for (int sc = 0; random_items < 260; sc++) begin
            quiet = (sc % 4 == 1);
            build_scene($urandom_range(1, 8));
            set_quad_count(scene_quads);
            if (sc == 2) hold_go = 1'b1;
            repeat (20) aimed_query();
        end
        quiet = 1'b0;

        // full store, then a count past the store size
        build_scene(256);
        set_quad_count(256);
        repeat (8) aimed_query();
        set_quad_count(511);
        repeat (4) aimed_query();
        set_quad_count($urandom_range(1, 255));
        scene_quads = 1;
        repeat (4) aimed_query();

        wait_idle();
        repeat (100) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("** ray_quad_intersection_top: PASSED **");
        end else begin
            $display("** ray_quad_intersection_top: FAILED **");
        end
        $finish;
    end

endmodule
